### design/pcas_pkg.sv
// Package: shared types, constants and CORDIC angle table for the polar sort block.
`timescale 1ns / 1ps
`default_nettype none
package pcas_pkg;
	localparam int MaxPointsDefault = 64;
	localparam int CordicSteps = 20;

	typedef struct packed {
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic               final_point;
	} in_item_t;

	typedef struct packed {
		logic [15:0] radius;
		logic [15:0] angle;
		logic        final_result;
	} out_item_t;

	typedef struct packed {
		logic [15:0] rad;
		logic [15:0] ang;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input transaction, start math
		logic step;      // one iteration of sqrt and CORDIC
		logic finish;    // compute final radius/angle into result regs
		logic write;     // write computed entry into store
		logic sort_init; // start a selection pass over the store
		logic sort_scan; // compare one entry in the pass
		logic emit;      // output the selected minimum
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic math_done;
		logic scan_done;
		logic store_empty_after;
	} dp_stat_t;

	function automatic logic [22:0] atan_entry(input logic [4:0] i);
		logic [22:0] r;
		unique case (i)
			5'd0:  r = 23'd2097152;
			5'd1:  r = 23'd1238021;
			5'd2:  r = 23'd654136;
			5'd3:  r = 23'd332050;
			5'd4:  r = 23'd166669;
			5'd5:  r = 23'd83416;
			5'd6:  r = 23'd41718;
			5'd7:  r = 23'd20860;
			5'd8:  r = 23'd10430;
			5'd9:  r = 23'd5215;
			5'd10: r = 23'd2608;
			5'd11: r = 23'd1304;
			5'd12: r = 23'd652;
			5'd13: r = 23'd326;
			5'd14: r = 23'd163;
			5'd15: r = 23'd81;
			5'd16: r = 23'd41;
			5'd17: r = 23'd20;
			5'd18: r = 23'd10;
			5'd19: r = 23'd5;
			default: r = 23'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### design/polar_convert_and_angle_sort.sv
// Top level: polar conversion and angle sort of a point set.
//  channel | handshake            | payload
//  input   | start & !busy        | in_item (coord_x, coord_y, final_point)
//  output  | done, one cycle each | result (radius, angle, final_result)
// Each point goes from accept through CALC (setup, shared sqrt/CORDIC iterations,
// done check), FIN (finish), WR (store write) and IDLE before the next accept.
// After a final point, each result takes SINIT, then SCAN for
// one selection pass over the n stored points through the store read port, then EMIT.
// Reset clears the control state and the fill count; no clearing pass.
// The receiver cannot stall: results are shown for one cycle with done.
`timescale 1ns / 1ps
`default_nettype none
module polar_convert_and_angle_sort #(
	parameter int MAX_POINTS = pcas_pkg::MaxPointsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire pcas_pkg::in_item_t  in_item,
	output logic                     done,
	output pcas_pkg::out_item_t      result
);
	pcas_pkg::dp_cmd_t  cmd;
	pcas_pkg::dp_stat_t stat;
	pcas_pkg::out_item_t dp_out, res_q;

	pcas_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .final_in(in_item.final_point),
		.stat(stat), .cmd(cmd), .busy(busy), .strobe(done)
	);

	pcas_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd),
		.stat(stat), .out_item(dp_out)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= dp_out;
	end
	assign result = res_q;
endmodule
`default_nettype wire

### design/pcas_datapath.sv
// Datapath: sqrt and CORDIC units, point store, selection-sort scanner.
`timescale 1ns / 1ps
`default_nettype none
module pcas_datapath #(
	parameter int MAX_POINTS = pcas_pkg::MaxPointsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pcas_pkg::in_item_t  in_item,
	input  wire pcas_pkg::dp_cmd_t   cmd,
	output pcas_pkg::dp_stat_t       stat,
	output pcas_pkg::out_item_t      out_item
);
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// input capture
	logic signed [16:0] x_q, y_q;
	logic               last_q;
	// sqrt
	logic [32:0] rem_q, root_q, bit_q, sum_q;
	// cordic
	logic signed [35:0] cx_q, cy_q;
	logic signed [24:0] z_q;
	logic [4:0]         it_q;
	logic               zero_y_q;
	// result
	pcas_pkg::entry_t   res_q;

	// store
	pcas_pkg::entry_t   mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] used_q;
	logic [CW-1:0]      cnt_q, left_q;
	logic [IW-1:0]      scan_q, best_i_q;
	pcas_pkg::entry_t   best_q, rd_q;
	logic               best_v_q, rd_v_q, scan_end_q;
	logic [IW-1:0]      rd_i_q;

	logic [16:0] ax, ay;
	assign ax = x_q[16] ? 17'(-x_q) : 17'(x_q);
	assign ay = y_q[16] ? 17'(-y_q) : 17'(y_q);

	logic [32:0] trial;
	assign trial = root_q + bit_q;

	logic signed [35:0] dx, dy;
	assign dx = cy_q >>> (it_q - 5'd1);
	assign dy = cx_q >>> (it_q - 5'd1);

	logic [32:0] sq_diff;
	logic [15:0] rad_fin;
	logic signed [24:0] th;
	logic [24:0] a_full;
	assign sq_diff = sum_q - 33'(root_q[16:0] * root_q[16:0]);
	assign rad_fin = (sq_diff > root_q) ? 16'(root_q + 33'd1) : root_q[15:0];
	always_comb begin
		if (zero_y_q || z_q < 0) th = '0;
		else if (z_q > 25'sd4194304) th = 25'sd4194304;
		else th = z_q;
		if (x_q == 0) a_full = (y_q > 0) ? 25'd4194304 : 25'd12582912;
		else if (!x_q[16] && !y_q[16]) a_full = 25'(th);
		else if (x_q[16] && !y_q[16]) a_full = 25'd8388608 - 25'(th);
		else if (x_q[16]) a_full = 25'd8388608 + 25'(th);
		else a_full = 25'd16777216 - 25'(th);
	end
	logic [24:0] a_rnd;
	assign a_rnd = a_full + 25'd128;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= 17'(in_item.coord_x);
			y_q    <= 17'(in_item.coord_y);
			last_q <= in_item.final_point;
		end
	end

	logic [32:0] sq_sum;
	assign sq_sum = 33'(ax[15:0] * ax[15:0]) + 33'(ay[15:0] * ay[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (cmd.load) begin
			it_q <= '0;
		end else if (cmd.step && it_q != 5'(pcas_pkg::CordicSteps + 1)) begin
			it_q <= it_q + 5'd1;
		end
	end

	// step 0 of "step" sets up the sum and CORDIC from the latched point
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (it_q == 5'd0) begin
				sum_q    <= sq_sum;
				rem_q    <= sq_sum;
				root_q   <= '0;
				bit_q    <= 33'h1_0000_0000;
				cx_q     <= 36'(ax) <<< 16;
				cy_q     <= 36'(ay) <<< 16;
				z_q      <= '0;
				zero_y_q <= (ay == 17'd0);
			end else begin
				if (bit_q != 0) begin
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				if (it_q <= 5'(pcas_pkg::CordicSteps)) begin
					if (cy_q >= 0) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						z_q  <= z_q + 25'(pcas_pkg::atan_entry(it_q - 5'd1));
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						z_q  <= z_q - 25'(pcas_pkg::atan_entry(it_q - 5'd1));
					end
				end
			end
		end
		if (cmd.finish) begin
			res_q.rad <= rad_fin;
			res_q.ang <= a_rnd[23:8];
		end
	end
	// 17 sqrt steps (bit from 2^32 down), 20 CORDIC: both done once it reaches 21
	assign stat.math_done = (it_q == 5'(pcas_pkg::CordicSteps + 1));

	// store and count
	always_ff @(posedge clk) begin
		if (cmd.write && cnt_q < CW'(MAX_POINTS))
			mem[cnt_q[IW-1:0]] <= res_q;
		rd_q <= mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			used_q     <= '0;
			left_q     <= '0;
			scan_q     <= '0;
			rd_v_q     <= 1'b0;
			rd_i_q     <= '0;
			scan_end_q <= 1'b0;
			best_v_q   <= 1'b0;
			best_i_q   <= '0;
		end else begin
			rd_v_q <= 1'b0;
			if (cmd.write) begin
				if (cnt_q < CW'(MAX_POINTS)) begin
					cnt_q <= cnt_q + CW'(1);
					used_q[cnt_q[IW-1:0]] <= 1'b1;
				end
				if (last_q) left_q <= (cnt_q < CW'(MAX_POINTS)) ?
					cnt_q + CW'(1) : cnt_q;
			end
			if (cmd.sort_init) begin
				scan_q     <= '0;
				best_v_q   <= 1'b0;
				scan_end_q <= 1'b0;
			end
			if (cmd.sort_scan && !scan_end_q) begin
				rd_v_q <= 1'b1;
				rd_i_q <= scan_q;
				if (CW'(scan_q) == cnt_q - CW'(1)) scan_end_q <= 1'b1;
				else scan_q <= scan_q + IW'(1);
			end
			if (rd_v_q && used_q[rd_i_q]) begin
				if (!best_v_q || rd_q.ang < best_q.ang ||
				    (rd_q.ang == best_q.ang && rd_q.rad > best_q.rad)) begin
					best_v_q <= 1'b1;
					best_i_q <= rd_i_q;
				end
			end
			if (cmd.emit) begin
				left_q <= left_q - CW'(1);
				if (left_q == CW'(1)) begin
					cnt_q  <= '0;
					used_q <= '0;
				end else begin
					used_q[best_i_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_q && used_q[rd_i_q] && (!best_v_q || rd_q.ang < best_q.ang ||
		    (rd_q.ang == best_q.ang && rd_q.rad > best_q.rad)))
			best_q <= rd_q;
	end

	assign stat.scan_done = scan_end_q && !rd_v_q;
	assign stat.store_empty_after = (left_q == CW'(1));

	assign out_item.radius       = best_q.rad;
	assign out_item.angle        = best_q.ang;
	assign out_item.final_result = (left_q == CW'(1));
endmodule
`default_nettype wire

### design/pcas_ctrl.sv
// Controller: sequences point math, store write and output sort passes.
`timescale 1ns / 1ps
`default_nettype none
module pcas_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               final_in,
	input  wire pcas_pkg::dp_stat_t stat,
	output pcas_pkg::dp_cmd_t       cmd,
	output logic                    busy,
	output logic                    strobe
);
	typedef enum logic [2:0] {IDLE, CALC, FIN, WR, SINIT, SCAN, EMIT} state_t;
	state_t st_q;
	logic   fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= IDLE;
			fin_q  <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (st_q)
				IDLE: if (start) begin
					st_q  <= CALC;
					fin_q <= final_in;
				end
				CALC: if (stat.math_done) st_q <= FIN;
				FIN:  st_q <= WR;
				WR:   st_q <= fin_q ? SINIT : IDLE;
				SINIT: st_q <= SCAN;
				SCAN: if (stat.scan_done) st_q <= EMIT;
				EMIT: begin
					strobe <= 1'b1;
					st_q   <= stat.store_empty_after ? IDLE : SINIT;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (st_q == IDLE) && start;
		cmd.step      = (st_q == CALC);
		cmd.finish    = (st_q == FIN);
		cmd.write     = (st_q == WR);
		cmd.sort_init = (st_q == SINIT);
		cmd.sort_scan = (st_q == SCAN);
		cmd.emit      = (st_q == EMIT);
	end
	assign busy = (st_q != IDLE);

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(st_q == EMIT)) else $error("strobe outside emit");
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted but not busy");
	a_emit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == EMIT) |-> $past(st_q == SCAN)) else $error("emit without scan");
endmodule
`default_nettype wire

### test/testbench.sv
// Testbench: random and directed point sets checked against a polar angle sort predictor.
`timescale 1ns / 1ps
`default_nettype none

class sorted_point_board;
	pcas_pkg::entry_t pending[$];
	pcas_pkg::out_item_t awaited[$];
	int mismatches;

	function automatic logic [15:0] radius_of(input int x, input int y);
		longint unsigned s, rem, root, b;
		s = longint'(x) * x + longint'(y) * y;
		rem = s;
		root = 0;
		b = 64'd1 << 32;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		if (s - root * root > root) root++;
		return root[15:0];
	endfunction

	function automatic int atan_step(input int i);
		int steps[20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
			10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
		return steps[i];
	endfunction

	function automatic longint quadrant_turns(input longint ax, input longint ay);
		longint cx, cy, z, dx, dy;
		cx = ax <<< 16;
		cy = ay <<< 16;
		z = 0;
		if (ay == 0) return 0;
		for (int i = 0; i < pcas_pkg::CordicSteps; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx;
				cy -= dy;
				z += longint'(atan_step(i));
			end else begin
				cx -= dx;
				cy += dy;
				z -= longint'(atan_step(i));
			end
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 <<< 22)) z = 64'sd1 <<< 22;
		return z;
	endfunction

	function automatic logic [15:0] angle_of(input int x, input int y);
		longint a, th, ax, ay;
		if (x == 0) begin
			a = (y > 0) ? (64'sd1 <<< 22) : (64'sd3 <<< 22);
		end else begin
			ax = (x < 0) ? -x : x;
			ay = (y < 0) ? -y : y;
			th = quadrant_turns(ax, ay);
			if (x > 0 && y >= 0) a = th;
			else if (x < 0 && y >= 0) a = (64'sd1 <<< 23) - th;
			else if (x < 0) a = (64'sd1 <<< 23) + th;
			else a = (64'sd1 <<< 24) - th;
		end
		a = (a + 128) >>> 8;
		return a[15:0];
	endfunction

	function automatic bit goes_first(input pcas_pkg::entry_t p, input pcas_pkg::entry_t q);
		if (p.ang != q.ang) return p.ang < q.ang;
		return p.rad > q.rad;
	endfunction

	function void note_point(input pcas_pkg::in_item_t it);
		pcas_pkg::entry_t e, s[$];
		pcas_pkg::out_item_t o;
		int j;
		if (pending.size() < pcas_pkg::MaxPointsDefault) begin
			e.rad = radius_of(int'(it.coord_x), int'(it.coord_y));
			e.ang = angle_of(int'(it.coord_x), int'(it.coord_y));
			pending.push_back(e);
		end
		if (!it.final_point) return;
		foreach (pending[i]) begin
			j = s.size();
			while (j > 0 && goes_first(pending[i], s[j - 1])) j--;
			s.insert(j, pending[i]);
		end
		foreach (s[i]) begin
			o.radius = s[i].rad;
			o.angle = s[i].ang;
			o.final_result = (i == s.size() - 1);
			awaited.push_back(o);
		end
		pending.delete();
	endfunction

	function void check_result(input pcas_pkg::out_item_t got);
		pcas_pkg::out_item_t w;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %p", got);
			return;
		end
		w = awaited.pop_front();
		if (got !== w) begin
			mismatches++;
			if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, got);
		end
	endfunction
endclass

module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic done;
	pcas_pkg::in_item_t in_item = '0;
	pcas_pkg::out_item_t result;
	sorted_point_board board = new();
	longint cycles = 0;
	int burst_left = 0;

	polar_convert_and_angle_sort i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) board.check_result(result);
		if (cycles > 3000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// start stays high within a burst; it drops only for a gap
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 40);
			if (gap > 0) begin
				start <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_item.coord_x <= x;
		in_item.coord_y <= y;
		in_item.final_point <= last;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_point(in_item);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int n, sent;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// extremes, axes, origin, all quadrants, equal keys
		send_point(16'sh7FFF, 16'sh7FFF, 0);
		send_point(-16'sh8000, -16'sh8000, 0);
		send_point(0, 0, 0);
		send_point(0, 256, 0);
		send_point(0, -256, 0);
		send_point(256, 0, 0);
		send_point(-256, 0, 0);
		send_point(-300, 500, 0);
		send_point(300, -500, 0);
		send_point(-300, -500, 0);
		send_point(300, 500, 0);
		send_point(300, 500, 0);
		send_point(600, 1000, 0);
		send_point(-16'sh8000, 16'sh7FFF, 1);
		send_point(5, 5, 1);
		// full store, then drop and final
		for (int i = 0; i < 66; i++) send_point(rnd_coord(), rnd_coord(), i == 65);
		sent = 0;
		while (sent < 240) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 8);
			for (int i = 0; i < n; i++) send_point(rnd_coord(), rnd_coord(), i == n - 1);
			sent += n;
		end
		start <= 0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.mismatches == 0 && board.awaited.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
